// ===== design/fm_register_port_with_two_timers_assert.svh =====
// Assertion macros used by the register port design file.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef FM_REGISTER_PORT_WITH_TWO_TIMERS_ASSERT_SVH
`define FM_REGISTER_PORT_WITH_TWO_TIMERS_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define FMRP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define FMRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`else

`define FMRP_ASSERT_NOW(lbl, ante, cons)
`define FMRP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/fmrp_pkg.sv =====
`default_nettype none

package fmrp_pkg;

  // Bus transaction kinds
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_UPDATE = 2'd2;

  // Register selects with special handling
  localparam logic [7:0] SEL_DAC_SAMPLE = 8'h2a;
  localparam logic [7:0] SEL_DAC_ENABLE = 8'h2b;
  localparam logic [7:0] SEL_TIMER_CTRL = 8'h27;
  localparam logic [7:0] SEL_TIMER_AHI  = 8'h24;
  localparam logic [7:0] SEL_TIMER_ALO  = 8'h25;
  localparam logic [7:0] SEL_TIMER_B    = 8'h26;

  // Periods in usec fit in 17 bits (max 288 * 256)
  localparam int PERIOD_W = 17;
  localparam logic [PERIOD_W-1:0] PERIOD_A_RST = 17'd18432;
  localparam logic [PERIOD_W-1:0] PERIOD_B_RST = 17'd73728;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  port;
    logic [7:0]  data;
    logic [31:0] now_usec;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status_flags;
    logic       forward_to_synth;
    logic       dac_sample_strobe;
    logic       dac_enable_strobe;
    logic [1:0] out_port;
    logic [7:0] out_data;
  } out_item_t;

  // Per-transaction control from the port decode to one timer
  typedef struct packed {
    logic                fire;
    logic                load;
    logic                update;
    logic                run;
    logic [PERIOD_W-1:0] period;
  } timer_ctl_t;

  // Timer A period: 18 * (1024 - count)
  function automatic logic [PERIOD_W-1:0] period_a(input logic [7:0] hi,
                                                   input logic [1:0] lo);
    logic [10:0] cnt;
    cnt = 11'd1024 - {1'b0, hi, lo};
    return PERIOD_W'(cnt) * PERIOD_W'(18);
  endfunction

  // Timer B period: 288 * (256 - load)
  function automatic logic [PERIOD_W-1:0] period_b(input logic [7:0] load);
    logic [8:0] cnt;
    cnt = 9'd256 - {1'b0, load};
    return PERIOD_W'(cnt) * PERIOD_W'(288);
  endfunction

endpackage

`default_nettype wire

// ===== design/fmrp_timer.sv =====
`default_nettype none

// One interval timer: elapsed accumulator and last-seen time.
module fmrp_timer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fmrp_pkg::timer_ctl_t ctl,
  input  wire logic [31:0]          now_usec,
  output logic                      tick
);

  logic [31:0] elapsed_r, elapsed_nxt;
  logic [31:0] last_r, last_nxt;
  logic [31:0] sum;

  // Accumulate elapsed time, subtract at most one period per update
  always_comb begin
    sum         = elapsed_r + (now_usec - last_r);
    elapsed_nxt = elapsed_r;
    last_nxt    = last_r;
    tick        = 1'b0;
    if (ctl.fire) begin
      if (ctl.load) begin
        elapsed_nxt = '0;
        last_nxt    = now_usec;
      end else if (ctl.update && ctl.run && (now_usec != last_r)) begin
        last_nxt = now_usec;
        if (sum >= 32'(ctl.period)) begin
          tick        = 1'b1;
          elapsed_nxt = sum - 32'(ctl.period);
        end else begin
          elapsed_nxt = sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      last_r    <= '0;
    end else begin
      elapsed_r <= elapsed_nxt;
      last_r    <= last_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/fm_register_port_with_two_timers.sv =====
// Register port front end with timers A and B.
// Input channel in_valid/in_ready/in_item carries bus writes, status
// reads and time updates, each stamped with a microsecond time.
// Result channel out_valid/out_ready/out_item returns exactly one result
// per transaction: overflow flags, forwarding and DAC strobe flags, and
// the echoed port and data byte.
// An accepted transaction goes into the input stage register, and its
// result then goes into the result register.
// Throughput: one transaction per cycle while the receiver does not stall;
// the decode, timer accumulate and period compare all sit between the input
// stage and the result register. Timer periods are kept as registers and
// recomputed on period writes. Reset (synchronous, active low) clears
// register selects, timer control, timer accumulators, overflow flags and both pipeline valid bits.
// When the receiver stalls, the result register holds; the input stage
// still takes one more transaction, and in_ready drops only when both
// the stage and the result register are full.
`default_nettype none

`include "fm_register_port_with_two_timers_assert.svh"

module fm_register_port_with_two_timers (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire fmrp_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output fmrp_pkg::out_item_t      out_item
);

  // Input stage
  fmrp_pkg::in_item_t stage_r;
  logic               stage_v_r;
  logic               advance;

  // Result register
  fmrp_pkg::out_item_t out_item_r, out_item_nxt;
  logic                out_v_r;

  // Port state
  logic [7:0] sel_r [2];
  logic [7:0] sel_nxt [2];
  logic [7:0] ctl_r, ctl_nxt;
  logic [7:0] a_hi_r, a_hi_nxt;
  logic [1:0] a_lo_r, a_lo_nxt;
  logic [fmrp_pkg::PERIOD_W-1:0] pa_r, pa_nxt;
  logic [fmrp_pkg::PERIOD_W-1:0] pb_r, pb_nxt;
  logic [1:0] ovf_r, ovf_base, ovf_nxt;

  // Decode results
  logic       part;
  logic [7:0] sel;
  logic [7:0] v;
  logic       fwd, dsam, den;
  logic       load_a, load_b, upd;
  logic       tick_a, tick_b;

  fmrp_pkg::timer_ctl_t ta_ctl, tb_ctl;

  assign advance  = stage_v_r && (!out_v_r || out_ready);
  assign in_ready = !stage_v_r || advance;

  assign part = stage_r.port[1];
  assign sel  = sel_r[part];

  // Transaction decode and register shadowing
  always_comb begin
    sel_nxt  = sel_r;
    ctl_nxt  = ctl_r;
    a_hi_nxt = a_hi_r;
    a_lo_nxt = a_lo_r;
    pa_nxt   = pa_r;
    pb_nxt   = pb_r;
    ovf_base = ovf_r;
    v        = stage_r.data;
    fwd      = 1'b0;
    dsam     = 1'b0;
    den      = 1'b0;
    load_a   = 1'b0;
    load_b   = 1'b0;
    upd      = 1'b0;
    case (stage_r.mode)
      fmrp_pkg::MODE_WRITE: begin
        fwd = 1'b1;
        if (!stage_r.port[0]) begin
          sel_nxt[part] = v;
        end else begin
          if (sel == fmrp_pkg::SEL_DAC_SAMPLE) begin
            dsam = 1'b1;
            fwd  = 1'b0;
          end
          if (sel == fmrp_pkg::SEL_DAC_ENABLE) begin
            den = 1'b1;
            fwd = 1'b0;
          end
          if (sel == fmrp_pkg::SEL_TIMER_CTRL) begin
            load_a = v[0] && !ctl_r[0];
            load_b = v[1] && !ctl_r[1];
            // overflow reset bits clear the flag and are not stored
            if (v[4]) begin
              ovf_base[0] = 1'b0;
              v[4]        = 1'b0;
            end
            if (v[5]) begin
              ovf_base[1] = 1'b0;
              v[5]        = 1'b0;
            end
          end
          if (!part) begin
            case (sel)
              fmrp_pkg::SEL_TIMER_CTRL: ctl_nxt = v;
              fmrp_pkg::SEL_TIMER_AHI: begin
                a_hi_nxt = v;
                pa_nxt   = fmrp_pkg::period_a(v, a_lo_r);
              end
              fmrp_pkg::SEL_TIMER_ALO: begin
                a_lo_nxt = v[1:0];
                pa_nxt   = fmrp_pkg::period_a(a_hi_r, v[1:0]);
              end
              fmrp_pkg::SEL_TIMER_B: pb_nxt = fmrp_pkg::period_b(v);
              default: ;
            endcase
          end
        end
      end
      fmrp_pkg::MODE_READ,
      fmrp_pkg::MODE_UPDATE: upd = 1'b1;
      default: ;
    endcase
  end

  // Timers
  assign ta_ctl = '{fire: advance, load: load_a, update: upd, run: ctl_r[0], period: pa_r};
  assign tb_ctl = '{fire: advance, load: load_b, update: upd, run: ctl_r[1], period: pb_r};

  fmrp_timer u_timer_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ta_ctl),
    .now_usec (stage_r.now_usec),
    .tick     (tick_a)
  );

  fmrp_timer u_timer_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (tb_ctl),
    .now_usec (stage_r.now_usec),
    .tick     (tick_b)
  );

  // Overflow flags set only when the timer's enable bit is on
  assign ovf_nxt = ovf_base | {tick_b & ctl_r[3], tick_a & ctl_r[2]};

  // Result assembly
  always_comb begin
    out_item_nxt.status_flags      = ovf_nxt;
    out_item_nxt.forward_to_synth  = fwd;
    out_item_nxt.dac_sample_strobe = dsam;
    out_item_nxt.dac_enable_strobe = den;
    out_item_nxt.out_port          = stage_r.port;
    out_item_nxt.out_data          = (stage_r.mode == fmrp_pkg::MODE_WRITE) ? v : 8'd0;
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        stage_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_r <= in_item;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  // Port state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r[0] <= '0;
      sel_r[1] <= '0;
      ctl_r    <= '0;
      a_hi_r   <= '0;
      a_lo_r   <= '0;
      pa_r     <= fmrp_pkg::PERIOD_A_RST;
      pb_r     <= fmrp_pkg::PERIOD_B_RST;
      ovf_r    <= '0;
    end else if (advance) begin
      sel_r[0] <= sel_nxt[0];
      sel_r[1] <= sel_nxt[1];
      ctl_r    <= ctl_nxt;
      a_hi_r   <= a_hi_nxt;
      a_lo_r   <= a_lo_nxt;
      pa_r     <= pa_nxt;
      pb_r     <= pb_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

  // Checks
  `FMRP_ASSERT_NEXT(a_adv_result, advance, out_v_r)
  `FMRP_ASSERT_NOW(a_ready_when_out_free, stage_v_r && !out_v_r, in_ready)
  `FMRP_ASSERT_NOW(a_full_stall, stage_v_r && out_v_r && !out_ready, !in_ready)
  `FMRP_ASSERT_NOW(a_ovf_a_enabled, $rose(ovf_r[0]), $past(ctl_r[2]))
  `FMRP_ASSERT_NOW(a_ovf_b_enabled, $rose(ovf_r[1]), $past(ctl_r[3]))

endmodule

`default_nettype wire

// ===== test/fm_register_port_checker.sv =====
`timescale 1ns / 100ps

module fm_register_port_checker
  import fmrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        mismatch_count,
  output int        pending_count,
  output int        checked_count,
  output int        flag_count
);

  // Timer control register bits
  localparam int CTL_RUN_A = 0;
  localparam int CTL_RUN_B = 1;
  localparam int CTL_IRQ_A = 2;
  localparam int CTL_IRQ_B = 3;
  localparam int CTL_CLR_A = 4;
  localparam int CTL_CLR_B = 5;

  // Shadow of the port and timer state
  logic [7:0]  sel_latch [2];
  logic [7:0]  ta_hi;
  logic [1:0]  ta_lo;
  logic [7:0]  tb_load;
  logic [7:0]  tmr_ctl;
  logic [31:0] ta_acc;
  logic [31:0] ta_stamp;
  logic [31:0] tb_acc;
  logic [31:0] tb_stamp;
  logic [1:0]  ovf;

  out_item_t port_results_due [$];

  // Result of one transaction; updates the shadow state
  function automatic out_item_t predict_port_result(input in_item_t t);
    out_item_t   r;
    logic [7:0]  v;
    logic [7:0]  sel;
    logic        part;
    logic [31:0] pa;
    logic [31:0] pb;
    r = '0;
    r.out_port = t.port;
    v = t.data;
    part = t.port[1];
    case (t.mode)
      MODE_WRITE: begin
        r.forward_to_synth = 1'b1;
        if (!t.port[0]) begin
          sel_latch[part] = v;
        end else begin
          sel = sel_latch[part];
          if (sel == SEL_DAC_SAMPLE) begin
            r.dac_sample_strobe = 1'b1;
            r.forward_to_synth = 1'b0;
          end
          if (sel == SEL_DAC_ENABLE) begin
            r.dac_enable_strobe = 1'b1;
            r.forward_to_synth = 1'b0;
          end
          // control write: start edges load, reset bits clear flags (both parts)
          if (sel == SEL_TIMER_CTRL) begin
            if (v[CTL_RUN_A] && !tmr_ctl[CTL_RUN_A]) begin
              ta_acc = '0;
              ta_stamp = t.now_usec;
            end
            if (v[CTL_RUN_B] && !tmr_ctl[CTL_RUN_B]) begin
              tb_acc = '0;
              tb_stamp = t.now_usec;
            end
            if (v[CTL_CLR_A]) begin
              ovf[0] = 1'b0;
              v[CTL_CLR_A] = 1'b0;
              tmr_ctl[CTL_CLR_A] = 1'b0;
            end
            if (v[CTL_CLR_B]) begin
              ovf[1] = 1'b0;
              v[CTL_CLR_B] = 1'b0;
              tmr_ctl[CTL_CLR_B] = 1'b0;
            end
          end
          // only part zero is shadowed
          if (!part) begin
            case (sel)
              SEL_TIMER_CTRL: tmr_ctl = v;
              SEL_TIMER_AHI:  ta_hi = v;
              SEL_TIMER_ALO:  ta_lo = v[1:0];
              SEL_TIMER_B:    tb_load = v;
              default: ;
            endcase
          end
        end
        r.out_data = v;
      end
      MODE_READ, MODE_UPDATE: begin
        pa = 32'd18 * (32'd1024 - {22'd0, ta_hi, ta_lo});
        pb = 32'd288 * (32'd256 - {24'd0, tb_load});
        if (tmr_ctl[CTL_RUN_A] && t.now_usec != ta_stamp) begin
          ta_acc = ta_acc + (t.now_usec - ta_stamp);
          ta_stamp = t.now_usec;
          if (ta_acc >= pa) begin
            if (tmr_ctl[CTL_IRQ_A]) ovf[0] = 1'b1;
            ta_acc = ta_acc - pa;
          end
        end
        if (tmr_ctl[CTL_RUN_B] && t.now_usec != tb_stamp) begin
          tb_acc = tb_acc + (t.now_usec - tb_stamp);
          tb_stamp = t.now_usec;
          if (tb_acc >= pb) begin
            if (tmr_ctl[CTL_IRQ_B]) ovf[1] = 1'b1;
            tb_acc = tb_acc - pb;
          end
        end
      end
      default: ;  // undefined mode: no state change
    endcase
    r.status_flags = ovf;
    return r;
  endfunction

  function automatic void check_field(input string field, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // Watch both channels; compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      sel_latch[0] = '0;
      sel_latch[1] = '0;
      ta_hi = '0;
      ta_lo = '0;
      tb_load = '0;
      tmr_ctl = '0;
      ta_acc = '0;
      ta_stamp = '0;
      tb_acc = '0;
      tb_stamp = '0;
      ovf = '0;
      port_results_due.delete();
      mismatch_count = 0;
      checked_count = 0;
      flag_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (port_results_due.size() == 0) begin
          $error("result transaction with no prediction pending: 0x%0h", out_item);
          mismatch_count++;
        end else begin
          want = port_results_due.pop_front();
          check_field("status_flags", 32'(want.status_flags),
                      32'(out_item.status_flags));
          check_field("forward_to_synth", 32'(want.forward_to_synth),
                      32'(out_item.forward_to_synth));
          check_field("dac_sample_strobe", 32'(want.dac_sample_strobe),
                      32'(out_item.dac_sample_strobe));
          check_field("dac_enable_strobe", 32'(want.dac_enable_strobe),
                      32'(out_item.dac_enable_strobe));
          check_field("out_port", 32'(want.out_port), 32'(out_item.out_port));
          check_field("out_data", 32'(want.out_data), 32'(out_item.out_data));
          checked_count++;
          if (want.status_flags != 2'b00) flag_count++;
        end
      end
      if (in_valid && in_ready) port_results_due.push_back(predict_port_result(in_item));
    end
    pending_count = port_results_due.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import fmrp_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [1:0] MODE_UNDEF = 2'd3;
  localparam logic [1:0] PORT_SEL0  = 2'd0;
  localparam logic [1:0] PORT_DATA0 = 2'd1;
  localparam logic [1:0] PORT_SEL1  = 2'd2;
  localparam logic [1:0] PORT_DATA1 = 2'd3;

  localparam int PHASE_ITEMS = 320;
  localparam int DRAIN_LIMIT = 20000;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int fail_count;
  int pending_count;
  int checked_count;
  int flag_count;

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int sent_by_mode [4] = '{0, 0, 0, 0};
  logic [31:0] now_us = 32'd0;

  fm_register_port_with_two_timers u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  fm_register_port_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .mismatch_count (fail_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count),
    .flag_count     (flag_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #400000;
    $display("fm_register_port_with_two_timers test failed");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Drive one transaction and hold it until accepted
  task automatic send_txn(input logic [1:0] mode, input logic [1:0] port,
                          input logic [7:0] data, input logic [31:0] now);
    in_item_t t;
    t.mode = mode;
    t.port = port;
    t.data = data;
    t.now_usec = now;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_by_mode[mode]++;
  endtask

  // Select then data write to one chip part
  task automatic reg_write(input logic part, input logic [7:0] sel,
                           input logic [7:0] val, input logic [31:0] now);
    send_txn(MODE_WRITE, {part, 1'b0}, sel, now);
    send_txn(MODE_WRITE, {part, 1'b1}, val, now);
  endtask

  // One random step: mostly register programming and timer polls, some noise
  task automatic random_step();
    int         pick;
    logic       part;
    logic [7:0] sel;
    logic [7:0] val;
    pick = $urandom_range(99);
    if ($urandom_range(19) == 0) now_us = $urandom();
    else now_us = now_us + $urandom_range(0, 600);
    if (pick < 45) begin
      part = ($urandom_range(3) == 0);
      val = 8'($urandom_range(255));
      case ($urandom_range(9))
        0, 1, 2: sel = SEL_TIMER_CTRL;
        3: begin
          sel = SEL_TIMER_AHI;
          if ($urandom_range(3) != 0) val = 8'($urandom_range(200, 255));
        end
        4: sel = SEL_TIMER_ALO;
        5: begin
          sel = SEL_TIMER_B;
          if ($urandom_range(3) != 0) val = 8'($urandom_range(200, 255));
        end
        6: sel = SEL_DAC_SAMPLE;
        7: sel = SEL_DAC_ENABLE;
        default: sel = 8'($urandom_range(255));
      endcase
      reg_write(part, sel, val, now_us);
    end else if (pick < 80) begin
      send_txn(($urandom_range(1) != 0) ? MODE_READ : MODE_UPDATE, 2'($urandom_range(3)),
               8'($urandom_range(255)), now_us);
    end else if (pick < 95) begin
      // lone select or data write
      send_txn(MODE_WRITE, 2'($urandom_range(3)), 8'($urandom_range(255)), now_us);
    end else begin
      send_txn(MODE_UNDEF, 2'($urandom_range(3)), 8'($urandom_range(255)), now_us);
    end
  endtask

  initial begin
    int drain;
    int total;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: shortest periods, both overflows, clears, DAC strobes, wrap
    send_txn(MODE_READ, PORT_SEL0, 8'h00, 32'd0);
    reg_write(1'b0, SEL_TIMER_AHI, 8'hFF, 32'd10);
    reg_write(1'b0, SEL_TIMER_ALO, 8'hFF, 32'd20);
    reg_write(1'b0, SEL_TIMER_B, 8'hFF, 32'd30);
    reg_write(1'b0, SEL_TIMER_CTRL, 8'h0F, 32'd1000);
    send_txn(MODE_UPDATE, PORT_DATA0, 8'hFF, 32'd1010);
    send_txn(MODE_READ, PORT_SEL1, 8'h00, 32'd1030);
    send_txn(MODE_READ, PORT_DATA1, 8'h00, 32'd1400);
    reg_write(1'b1, SEL_TIMER_CTRL, 8'h30, 32'd1500);
    reg_write(1'b0, SEL_TIMER_CTRL, 8'h3F, 32'd1600);
    reg_write(1'b1, SEL_DAC_SAMPLE, 8'h80, 32'd1700);
    reg_write(1'b0, SEL_DAC_ENABLE, 8'h80, 32'd1800);
    send_txn(MODE_UNDEF, PORT_DATA1, 8'hFF, 32'hFFFF_FFFF);
    send_txn(MODE_UPDATE, PORT_SEL0, 8'h00, 32'hFFFF_FFFF);
    send_txn(MODE_READ, PORT_SEL0, 8'h00, 32'h0000_0005);
    reg_write(1'b0, SEL_TIMER_AHI, 8'h00, 32'd6);
    reg_write(1'b0, SEL_TIMER_B, 8'h00, 32'd8);

    // Random phases: no idling, sender idle, receiver stalls, both
    now_us = 32'hFFF0_0000;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 72; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 72; end
        default: begin in_idle_pct = 29; out_stall_pct = 29; end
      endcase
      total = sent_by_mode[0] + sent_by_mode[1] + sent_by_mode[2] + sent_by_mode[3];
      while (sent_by_mode[0] + sent_by_mode[1] + sent_by_mode[2] + sent_by_mode[3]
             < total + PHASE_ITEMS) begin
        random_step();
      end
    end
    in_valid <= 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;

    // Drain, then watch for stray results
    drain = 0;
    while (pending_count != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);

    total = sent_by_mode[0] + sent_by_mode[1] + sent_by_mode[2] + sent_by_mode[3];
    $display("Run: %0d transactions (%0d writes, %0d reads, %0d updates, %0d bad mode)",
             total, sent_by_mode[0], sent_by_mode[1], sent_by_mode[2], sent_by_mode[3]);
    $display("Run: %0d results compared, %0d with an overflow flag set",
             checked_count, flag_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("fm_register_port_with_two_timers test passed");
    end else begin
      $display("fm_register_port_with_two_timers test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/fmrp_pkg.sv
design/fmrp_timer.sv
design/fm_register_port_with_two_timers.sv
test/fm_register_port_checker.sv
test/tb_top.sv
